[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/ieu_pkg.sv]
`default_nettype none
package ieu_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADDU = 5'd1, OP_SUB = 5'd2, OP_SUBU = 5'd3,
    OP_AND = 5'd4, OP_OR = 5'd5, OP_XOR = 5'd6, OP_SLL = 5'd7,
    OP_SLLV = 5'd8, OP_SRA = 5'd9, OP_SRAV = 5'd10, OP_SRL = 5'd11,
    OP_SRLV = 5'd12, OP_SLT = 5'd13, OP_SLTU = 5'd14, OP_ADDI = 5'd15,
    OP_ADDIU = 5'd16, OP_ANDI = 5'd17, OP_ORI = 5'd18, OP_XORI = 5'd19,
    OP_LUI = 5'd20, OP_SLTI = 5'd21, OP_SLTIU = 5'd22, OP_MULT = 5'd23,
    OP_MULTU = 5'd24, OP_DIV = 5'd25, OP_DIVU = 5'd26, OP_MFHI = 5'd27,
    OP_MFLO = 5'd28, OP_MTHI = 5'd29, OP_MTLO = 5'd30, OP_NONE = 5'd31
  } op_t;

  typedef struct packed {
    logic [4:0]         req_type;
    logic signed [31:0] rs_value;
    logic signed [31:0] rt_value;
    logic signed [15:0] immediate;
    logic [4:0]         shift_amount;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               write_result;
    logic               status;
  } out_word_t;

  // Classified instruction handed from front to back.
  typedef enum logic [2:0] {
    K_ALU = 3'b001, K_MUL = 3'b010, K_DIV = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    op_t         op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] alu_res;
    logic        write_result;
    logic        status;
    logic        sgn;
  } cmd_t;

  localparam int unsigned QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

[rtl/core/integer_execute_unit_hilo_unit.sv]
`default_nettype none
// Integer execute unit with a HI/LO register pair.
// Input channel in_valid/in_ready/in_word carries one instruction word (operation
// code, two source operands, immediate and constant shift amount). Output channel
// out_valid/out_ready/out_word returns exactly one result word per instruction, in
// order: destination value, write enable and an overflow status bit.
// A front decoder computes all single-cycle operations and classifies the word; a
// two-entry queue separates it from the back end, which owns HI/LO and the
// iterative multiply and divide units.
// A single-cycle operation is written into the queue and then into the output register
// before out_valid rises. The back end takes one single-cycle word per cycle while the
// receiver does not stall; a multiply holds it for four 16x16 partial products and a
// sign fix, a divide for one quotient bit per cycle and a sign fix. A divide by zero
// leaves HI/LO untouched. Moves from HI/LO wait behind any earlier multiply or divide,
// so they always see its result.
// Reset clears HI/LO, the queue and the output valid flag. When the receiver
// stalls, the output register holds its word, the queue fills and in_ready falls.
module integer_execute_unit_hilo_unit
  import ieu_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire in_word_t in_word,
  output logic       out_valid,
  input  wire        out_ready,
  output out_word_t  out_word
);
`include "assert_macros.svh"

  cmd_t cmd, head;
  logic full, empty, pop;

  ieu_front u_front (.in_word(in_word), .cmd(cmd));

  ieu_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(in_valid && !full), .push_data(cmd),
    .full(full), .pop(pop), .empty(empty), .head(head)
  );

  assign in_ready = !full;

  ieu_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(!empty), .cmd(head), .cmd_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  // A word is only taken from the queue when one is there.
  `ASSERT_IMPL(a_pop_nonempty, clk, rst_n, pop, !empty)
  // An overflowing word never writes the destination.
  `ASSERT_IMPL(a_ovf_nowrite, clk, rst_n, out_valid && out_word.status, !out_word.write_result)
  // A stalled result word holds its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(out_word))

endmodule
`default_nettype wire

[rtl/core/ieu_front.sv]
`default_nettype none
module ieu_front
  import ieu_pkg::*;
(
  input  wire in_word_t in_word,
  output cmd_t          cmd
);
  logic [31:0] rs, rt, imm_s, imm_z, b, sum, diff, sr;
  logic [4:0]  sh;
  logic        ovf_add, ovf_sub;
  op_t         op;

  always_comb begin
    op    = op_t'(in_word.req_type);
    rs    = in_word.rs_value;
    rt    = in_word.rt_value;
    imm_s = {{16{in_word.immediate[15]}}, in_word.immediate};
    imm_z = {16'd0, in_word.immediate};
    b     = (op == OP_ADDI || op == OP_ADDIU || op == OP_SLTI || op == OP_SLTIU) ? imm_s : rt;
    sum   = rs + b;
    diff  = rs - rt;
    ovf_add = (rs[31] == b[31]) && (sum[31] != rs[31]);
    ovf_sub = (rs[31] != rt[31]) && (diff[31] != rs[31]);
    sh    = (op == OP_SLL || op == OP_SRA || op == OP_SRL) ? in_word.shift_amount : rs[4:0];
    sr    = (op == OP_SRA || op == OP_SRAV) ? 32'($signed(rt) >>> sh) : rt >> sh;
    cmd = '0;
    cmd.kind = K_ALU;
    cmd.op = op;
    cmd.a = rs;
    cmd.b = rt;
    cmd.write_result = 1'b1;
    cmd.sgn = (op == OP_MULT || op == OP_DIV);
    unique case (op)
      OP_ADD, OP_ADDI: begin
        if (ovf_add) begin
          cmd.status = 1'b1;
          cmd.write_result = 1'b0;
        end else cmd.alu_res = sum;
      end
      OP_ADDU, OP_ADDIU: cmd.alu_res = sum;
      OP_SUB: begin
        if (ovf_sub) begin
          cmd.status = 1'b1;
          cmd.write_result = 1'b0;
        end else cmd.alu_res = diff;
      end
      OP_SUBU: cmd.alu_res = diff;
      OP_AND: cmd.alu_res = rs & rt;
      OP_OR:  cmd.alu_res = rs | rt;
      OP_XOR: cmd.alu_res = rs ^ rt;
      OP_SLL, OP_SLLV: cmd.alu_res = rt << sh;
      OP_SRA, OP_SRAV, OP_SRL, OP_SRLV: cmd.alu_res = sr;
      OP_SLT, OP_SLTI: cmd.alu_res = {31'd0, $signed(rs) < $signed(b)};
      OP_SLTU, OP_SLTIU: cmd.alu_res = {31'd0, rs < b};
      OP_ANDI: cmd.alu_res = rs & imm_z;
      OP_ORI:  cmd.alu_res = rs | imm_z;
      OP_XORI: cmd.alu_res = rs ^ imm_z;
      OP_LUI:  cmd.alu_res = {in_word.immediate, 16'd0};
      OP_MULT, OP_MULTU: begin
        cmd.kind = K_MUL;
        cmd.write_result = 1'b0;
      end
      OP_DIV, OP_DIVU: begin
        cmd.kind = K_DIV;
        cmd.write_result = 1'b0;
      end
      OP_MFHI, OP_MFLO: ;
      OP_MTHI, OP_MTLO, OP_NONE: cmd.write_result = 1'b0;
      default: cmd.write_result = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/ieu_queue.sv]
`default_nettype none
module ieu_queue
  import ieu_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push,
  input  wire cmd_t  push_data,
  output logic       full,
  input  wire        pop,
  output logic       empty,
  output cmd_t       head
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

[rtl/core/ieu_back.sv]
`default_nettype none
module ieu_back
  import ieu_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              cmd_valid,
  input  wire cmd_t        cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  wire              out_ready,
  output out_word_t        out_word
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_FIX = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] hi_r, hi_nxt, lo_r, lo_nxt;
  logic        ov_r, ov_nxt;
  out_word_t   ow_r, ow_nxt;
  // Multiplier: four 16x16 partial products, one per cycle.
  logic [1:0]  step_r, step_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic        na_r, na_nxt, nb_r, nb_nxt;
  // Divider: restoring, one quotient bit per cycle.
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [32:0] trial;
  logic [31:0] pp;
  logic [15:0] pa, pb;
  logic [63:0] prod;
  logic        free;

  assign out_valid = ov_r;
  assign out_word  = ow_r;
  assign free      = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    hi_nxt = hi_r; lo_nxt = lo_r;
    ov_nxt = ov_r && !out_ready;
    ow_nxt = ow_r;
    step_nxt = step_r; acc_nxt = acc_r;
    ma_nxt = ma_r; mb_nxt = mb_r; na_nxt = na_r; nb_nxt = nb_r;
    cnt_nxt = cnt_r; rem_nxt = rem_r; quo_nxt = quo_r;
    cmd_pop = 1'b0;
    pa = step_r[0] ? ma_r[31:16] : ma_r[15:0];
    pb = step_r[1] ? mb_r[31:16] : mb_r[15:0];
    pp = pa * pb;
    trial = {rem_r, quo_r[31]} - {1'b0, mb_r};
    prod = (na_r != nb_r) ? (64'd0 - acc_r) : acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && free) begin
          cmd_pop = 1'b1;
          na_nxt = cmd.sgn && cmd.a[31];
          nb_nxt = cmd.sgn && cmd.b[31];
          ma_nxt = (cmd.sgn && cmd.a[31]) ? 32'd0 - cmd.a : cmd.a;
          mb_nxt = (cmd.sgn && cmd.b[31]) ? 32'd0 - cmd.b : cmd.b;
          acc_nxt = '0; step_nxt = '0; cnt_nxt = '0; rem_nxt = '0;
          quo_nxt = (cmd.sgn && cmd.a[31]) ? 32'd0 - cmd.a : cmd.a;
          ov_nxt = 1'b1;
          ow_nxt.result_value = cmd.alu_res;
          ow_nxt.write_result = cmd.write_result;
          ow_nxt.status = cmd.status;
          unique case (cmd.kind)
            K_MUL: state_nxt = S_MUL;
            K_DIV: state_nxt = (cmd.b == '0) ? S_IDLE : S_DIV;
            default: begin
              if (cmd.op == OP_MFHI) ow_nxt.result_value = hi_r;
              if (cmd.op == OP_MFLO) ow_nxt.result_value = lo_r;
              if (cmd.op == OP_MTHI) hi_nxt = cmd.a;
              if (cmd.op == OP_MTLO) lo_nxt = cmd.a;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt = acc_r + (64'(pp) << (6'(step_r[0]) * 6'd16 + 6'(step_r[1]) * 6'd16));
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) state_nxt = S_FIX;
      end
      S_DIV: begin
        if (!trial[32]) begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[30:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd31) state_nxt = S_FIX;
      end
      S_FIX: begin
        if (cnt_r == 6'd32) begin
          lo_nxt = (na_r != nb_r) ? 32'd0 - quo_r : quo_r;
          hi_nxt = na_r ? 32'd0 - rem_r : rem_r;
        end else begin
          hi_nxt = prod[63:32];
          lo_nxt = prod[31:0];
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    ow_r <= ow_nxt;
    step_r <= step_nxt; acc_r <= acc_nxt;
    ma_r <= ma_nxt; mb_r <= mb_nxt; na_r <= na_nxt; nb_r <= nb_nxt;
    cnt_r <= cnt_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt;
  end
endmodule
`default_nettype wire

[verif/integer_execute_unit_hilo_unit_checker.sv]
module integer_execute_unit_hilo_unit_checker
  import ieu_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  input  wire       in_ready,
  input  in_word_t  in_word,
  input  wire       out_valid,
  input  wire       out_ready,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);

  // HI/LO as the unit should hold them.
  logic [31:0] hi_q;
  logic [31:0] lo_q;
  out_word_t   expected_words[$];

  function automatic logic [31:0] sra_word(logic [31:0] x, logic [4:0] sh);
    return $unsigned($signed(x) >>> sh);
  endfunction

  function automatic logic less_signed(logic [31:0] a, logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  task automatic execute_word(input in_word_t w);
    out_word_t   o;
    logic [31:0] rs, rt, imm_s, imm_z, r, ma, mb, q, m;
    logic [63:0] p;
    logic        na, nb;
    op_t         op;
    rs = w.rs_value;
    rt = w.rt_value;
    imm_s = {{16{w.immediate[15]}}, w.immediate};
    imm_z = {16'h0, w.immediate};
    op = op_t'(w.req_type);
    o = '0;
    o.write_result = 1'b1;
    case (op)
      OP_ADD, OP_ADDI: begin
        m = (op == OP_ADD) ? rt : imm_s;
        r = rs + m;
        if (((rs ^ r) & (m ^ r)) >> 31) begin
          o.status = 1'b1;
          o.write_result = 1'b0;
        end else o.result_value = r;
      end
      OP_ADDU:  o.result_value = rs + rt;
      OP_SUB: begin
        r = rs - rt;
        if (((rs ^ rt) & (rs ^ r)) >> 31) begin
          o.status = 1'b1;
          o.write_result = 1'b0;
        end else o.result_value = r;
      end
      OP_SUBU:  o.result_value = rs - rt;
      OP_AND:   o.result_value = rs & rt;
      OP_OR:    o.result_value = rs | rt;
      OP_XOR:   o.result_value = rs ^ rt;
      OP_SLL:   o.result_value = rt << w.shift_amount;
      OP_SLLV:  o.result_value = rt << rs[4:0];
      OP_SRA:   o.result_value = sra_word(rt, w.shift_amount);
      OP_SRAV:  o.result_value = sra_word(rt, rs[4:0]);
      OP_SRL:   o.result_value = rt >> w.shift_amount;
      OP_SRLV:  o.result_value = rt >> rs[4:0];
      OP_SLT:   o.result_value = {31'h0, less_signed(rs, rt)};
      OP_SLTU:  o.result_value = {31'h0, rs < rt};
      OP_ADDIU: o.result_value = rs + imm_s;
      OP_ANDI:  o.result_value = rs & imm_z;
      OP_ORI:   o.result_value = rs | imm_z;
      OP_XORI:  o.result_value = rs ^ imm_z;
      OP_LUI:   o.result_value = imm_z << 16;
      OP_SLTI:  o.result_value = {31'h0, less_signed(rs, imm_s)};
      OP_SLTIU: o.result_value = {31'h0, rs < imm_s};
      OP_MULT, OP_MULTU: begin
        if (op == OP_MULT) p = $signed(rs) * $signed(rt);
        else p = {32'h0, rs} * {32'h0, rt};
        {hi_q, lo_q} = p;
        o.write_result = 1'b0;
      end
      OP_DIV: begin
        // Work on magnitudes so that the most negative value over minus one wraps.
        if (rt != 0) begin
          na = rs[31];
          nb = rt[31];
          ma = na ? -rs : rs;
          mb = nb ? -rt : rt;
          q = ma / mb;
          r = ma % mb;
          lo_q = (na != nb) ? -q : q;
          hi_q = na ? -r : r;
        end
        o.write_result = 1'b0;
      end
      OP_DIVU: begin
        if (rt != 0) begin
          lo_q = rs / rt;
          hi_q = rs % rt;
        end
        o.write_result = 1'b0;
      end
      OP_MFHI:  o.result_value = hi_q;
      OP_MFLO:  o.result_value = lo_q;
      OP_MTHI: begin
        hi_q = rs;
        o.write_result = 1'b0;
      end
      OP_MTLO: begin
        lo_q = rs;
        o.write_result = 1'b0;
      end
      default:  o.write_result = 1'b0;
    endcase
    expected_words.push_back(o);
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      hi_q = '0;
      lo_q = '0;
      fail_count <= 0;
      result_count <= 0;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) execute_word(in_word);
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_words.size() == 0) begin
          if (fail_count < 10) $display("Unexpected result word %h", out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.result_value !== out_word.result_value ||
              e.write_result !== out_word.write_result || e.status !== out_word.status) begin
            if (fail_count < 10)
              $display("Mismatch: expected value %h write %b status %b, got %h %b %b",
                       e.result_value, e.write_result, e.status, out_word.result_value,
                       out_word.write_result, out_word.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count = expected_words.size();
  end

endmodule

[verif/integer_execute_unit_hilo_unit_test.sv]
module integer_execute_unit_hilo_unit_test;
  import ieu_pkg::*;

  // The watchdog limit covers a divide behind a long receiver stall, several times over.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;
  int        fail_count;
  int        pending_count;
  int        result_count;
  int        words_sent = 0;
  int        idle_cycles = 0;
  // Percentages of cycles in which the sender idles and the receiver stalls.
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  always #5 clk = ~clk;

  integer_execute_unit_hilo_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  integer_execute_unit_hilo_unit_checker checker_inst (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  // The receiver decides afresh every cycle whether it will take a word.
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The watchdog counts cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d words outstanding", pending_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // An operand picked from the corner values half of the time.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return $urandom_range(40);
      default: return $urandom();
    endcase
  endfunction

  // Sends one word, with a random number of idle cycles ahead of it.
  task automatic send_word(input op_t op, input logic [31:0] rs, input logic [31:0] rt,
                           input logic [15:0] imm, input logic [4:0] sa);
    in_word_t w;
    w.req_type = op;
    w.rs_value = rs;
    w.rt_value = rt;
    w.immediate = imm;
    w.shift_amount = sa;
    // Valid is lowered while the sender idles, so no word is offered twice.
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_random();
    op_t op;
    logic [31:0] rt;
    op = op_t'($urandom_range(31));
    rt = pick_operand();
    // Divides and multiplies are slow, so about half are swapped for quicker words.
    if ((op >= OP_MULT && op <= OP_DIVU) && $urandom_range(1)) op = op_t'($urandom_range(22));
    if ((op == OP_DIV || op == OP_DIVU) && $urandom_range(5) == 0) rt = 32'h0;
    send_word(op, pick_operand(), rt, 16'($urandom()), 5'($urandom()));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words: every operation, overflow edges, divide corners and HI/LO moves.
    send_word(OP_ADD, 32'h7FFF_FFFF, 32'h1, 16'h0, 5'd0);
    send_word(OP_SUB, 32'h8000_0000, 32'h1, 16'h0, 5'd0);
    send_word(OP_ADDI, 32'h7FFF_FFFF, 32'h0, 16'h0001, 5'd0);
    send_word(OP_ADDI, 32'h8000_0000, 32'h0, 16'h8000, 5'd0);
    send_word(OP_SRA, 32'h0, 32'h8000_0000, 16'h0, 5'd31);
    send_word(OP_SRAV, 32'hFFFF_FFE4, 32'h8000_0001, 16'h0, 5'd0);
    send_word(OP_SLLV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 5'd0);
    send_word(OP_SLTIU, 32'h0000_0001, 32'h0, 16'hFFFF, 5'd0);
    send_word(OP_LUI, 32'h0, 32'h0, 16'hFFFF, 5'd0);
    send_word(OP_MFHI, 32'h0, 32'h0, 16'h0, 5'd0);
    send_word(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 16'h0, 5'd0);
    send_word(OP_MFHI, 32'h0, 32'h0, 16'h0, 5'd0);
    send_word(OP_MFLO, 32'h0, 32'h0, 16'h0, 5'd0);
    send_word(OP_DIV, 32'hFFFF_FFF9, 32'h2, 16'h0, 5'd0);
    send_word(OP_DIVU, 32'h1234, 32'h0, 16'h0, 5'd0);
    send_word(OP_MFLO, 32'h0, 32'h0, 16'h0, 5'd0);
    send_word(OP_MULT, 32'h8000_0000, 32'h8000_0000, 16'h0, 5'd0);
    send_word(OP_MFHI, 32'h0, 32'h0, 16'h0, 5'd0);
    send_word(OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 5'd0);
    send_word(OP_MTHI, 32'hDEAD_BEEF, 32'h0, 16'h0, 5'd0);
    send_word(OP_MTLO, 32'h0BAD_F00D, 32'h0, 16'h0, 5'd0);
    send_word(OP_MFHI, 32'h0, 32'h0, 16'h0, 5'd0);
    send_word(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'd31);
    for (int k = 0; k <= OP_NONE; k++) send_word(op_t'(k), $urandom(), $urandom(),
                                                16'($urandom()), 5'($urandom()));

    // Random words in phases of idling and stalling, with an unhindered phase first.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 22 : 73) : 0;
      for (int n = 0; n < RANDOM_WORDS / 4; n++) send_random();
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d words covering all operations and HI/LO traffic; checked %0d results.",
             words_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/ieu_pkg.sv
rtl/core/ieu_front.sv
rtl/core/ieu_queue.sv
rtl/core/ieu_back.sv
rtl/core/integer_execute_unit_hilo_unit.sv
verif/integer_execute_unit_hilo_unit_checker.sv
verif/integer_execute_unit_hilo_unit_test.sv
